// ===== rtl/core/icu_pkg.sv =====
package icu_pkg;

	// Configuration register indexes
	localparam logic CFG_RANGE_LOW  = 1'b0;
	localparam logic CFG_RANGE_HIGH = 1'b1;

	// Reset values of the range registers, Q16.16
	localparam logic signed [31:0] RANGE_LOW_RST  = 32'sd0;
	localparam logic signed [31:0] RANGE_HIGH_RST = 32'sd65536;

	// One excluded interval
	typedef struct packed {
		logic signed [31:0] interval_low;
		logic signed [31:0] interval_high;
		logic               last_interval;
	} icu_in_t;

	// One free gap
	typedef struct packed {
		logic signed [31:0] gap_low;
		logic signed [31:0] gap_high;
		logic        [31:0] gap_length;
		logic               last_gap;
	} icu_out_t;

endpackage

// ===== rtl/core/icu_mem.sv =====
module icu_mem import icu_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [DEPTH];
	logic [63:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/icu_seq.sv =====
module icu_seq import icu_pkg::*; #(
	parameter int MAX_INTERVALS = 32,
	parameter int AW = 5,
	parameter int CW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  icu_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output icu_out_t             out_data,
	input  logic signed [31:0]   range_low,
	input  logic signed [31:0]   range_high,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [63:0]          mem_wdata,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	input  logic [63:0]          mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_INSERT,
		ST_EM_START,
		ST_EM_FIRST,
		ST_EM_PROC,
		ST_EM_CLOSE,
		ST_EM_TAIL,
		ST_EM_FIN
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic signed [31:0] new_lo_q;
	logic signed [31:0] new_hi_q;
	logic               last_q;
	logic signed [31:0] cur_lo_q;
	logic signed [31:0] cur_hi_q;
	logic signed [31:0] prev_q;
	icu_out_t           pend_q;
	logic               pend_valid_q;
	icu_out_t           out_q;
	logic               out_valid_q;

	logic               in_accept;
	logic               full;
	logic               out_free;
	logic               out_load;
	logic signed [31:0] rd_lo;
	logic signed [31:0] rd_hi;
	logic               shift;
	logic               merge;
	logic               gap_want;
	logic signed [31:0] gap_lo;
	logic signed [31:0] gap_hi;
	logic               blocked;
	logic signed [31:0] cur_hi_clip;
	logic               idx_at_end;
	state_t             after_store;

	// Builds a gap transaction; the length saturates at zero for a reversed pair.
	function automatic icu_out_t make_gap(input logic signed [31:0] lo,
			input logic signed [31:0] hi, input logic last);
		logic signed [32:0] diff;
		icu_out_t g;
		diff = 33'(hi) - 33'(lo);
		g.gap_low    = lo;
		g.gap_high   = hi;
		g.gap_length = diff[32] ? 32'd0 : diff[31:0];
		g.last_gap   = last;
		return g;
	endfunction

	assign in_stall    = (state_q != ST_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign full        = (count_q == CW'(MAX_INTERVALS));
	assign out_free    = !out_valid_q || !out_stall;
	assign rd_lo       = $signed(mem_rdata[63:32]);
	assign rd_hi       = $signed(mem_rdata[31:0]);
	assign shift       = (rd_lo > new_lo_q);
	assign merge       = (rd_lo <= cur_hi_q);
	assign cur_hi_clip = (cur_hi_q < range_high) ? cur_hi_q : range_high;
	assign idx_at_end  = ((idx_q + CW'(1)) == count_q);
	assign after_store = last_q ? ST_EM_START : ST_IDLE;
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;

	// The output register is loaded with a pushed-out gap or with the final one.
	assign out_load = (gap_want && !blocked && pend_valid_q) ||
		((state_q == ST_EM_FIN) && !blocked);

	// Gap candidate of the current merge step and the back-pressure it meets
	always_comb begin
		gap_want = 1'b0;
		gap_lo   = prev_q;
		gap_hi   = cur_lo_q;
		blocked  = 1'b0;
		unique case (state_q)
			ST_EM_PROC: begin
				gap_want = !merge && (cur_lo_q > prev_q);
			end
			ST_EM_CLOSE: begin
				gap_want = (cur_lo_q > prev_q);
			end
			ST_EM_TAIL: begin
				gap_want = (prev_q < range_high);
				gap_hi   = range_high;
			end
			default: begin
				gap_want = 1'b0;
			end
		endcase
		if (state_q == ST_EM_FIN) begin
			blocked = !out_free;
		end else begin
			blocked = gap_want && pend_valid_q && !out_free;
		end
	end

	// Memory accesses: the insertion walk moves entries up from the top,
	// the merge pass reads the sorted entries in order.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && !full) begin
					if (count_q == '0) begin
						mem_we    = 1'b1;
						mem_wdata = {in_data.interval_low, in_data.interval_high};
					end else begin
						mem_re    = 1'b1;
						mem_raddr = AW'(count_q - CW'(1));
					end
				end
			end
			ST_WALK: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(idx_q + CW'(1));
				if (shift) begin
					mem_wdata = mem_rdata;
					if (idx_q != '0) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(idx_q - CW'(1));
					end
				end else begin
					mem_wdata = {new_lo_q, new_hi_q};
				end
			end
			ST_INSERT: begin
				mem_we    = 1'b1;
				mem_wdata = {new_lo_q, new_hi_q};
			end
			ST_EM_START: begin
				mem_re = (count_q != '0);
			end
			ST_EM_FIRST: begin
				if (count_q != CW'(1)) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(1);
				end
			end
			ST_EM_PROC: begin
				if (!blocked && !idx_at_end) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(idx_q + CW'(1));
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Sequencer, merge state, pending gap and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// A new gap pushes the pending one out; the newest stays back so
			// that the final gap can still be marked.
			if (gap_want && !blocked) begin
				if (pend_valid_q) begin
					out_q <= pend_q;
				end
				pend_q       <= make_gap(gap_lo, gap_hi, 1'b0);
				pend_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						new_lo_q <= in_data.interval_low;
						new_hi_q <= in_data.interval_high;
						last_q   <= in_data.last_interval;
						if (full || count_q == '0) begin
							if (!full) begin
								count_q <= CW'(1);
							end
							state_q <= in_data.last_interval ? ST_EM_START : ST_IDLE;
						end else begin
							idx_q   <= count_q - CW'(1);
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (shift) begin
						if (idx_q == '0) begin
							state_q <= ST_INSERT;
						end else begin
							idx_q <= idx_q - CW'(1);
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= after_store;
					end
				end
				ST_INSERT: begin
					count_q <= count_q + CW'(1);
					state_q <= after_store;
				end
				ST_EM_START: begin
					prev_q  <= range_low;
					state_q <= (count_q == '0) ? ST_EM_TAIL : ST_EM_FIRST;
				end
				ST_EM_FIRST: begin
					cur_lo_q <= rd_lo;
					cur_hi_q <= rd_hi;
					idx_q    <= CW'(1);
					state_q  <= (count_q == CW'(1)) ? ST_EM_CLOSE : ST_EM_PROC;
				end
				ST_EM_PROC: begin
					if (!blocked) begin
						if (merge) begin
							if (rd_hi > cur_hi_q) begin
								cur_hi_q <= rd_hi;
							end
						end else begin
							prev_q   <= cur_hi_clip;
							cur_lo_q <= rd_lo;
							cur_hi_q <= rd_hi;
						end
						if (idx_at_end) begin
							state_q <= ST_EM_CLOSE;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				ST_EM_CLOSE: begin
					if (!blocked) begin
						prev_q  <= cur_hi_clip;
						state_q <= ST_EM_TAIL;
					end
				end
				ST_EM_TAIL: begin
					if (!blocked) begin
						state_q <= ST_EM_FIN;
					end
				end
				ST_EM_FIN: begin
					if (!blocked) begin
						if (pend_valid_q) begin
							out_q <= make_gap(pend_q.gap_low, pend_q.gap_high, 1'b1);
						end else begin
							out_q <= make_gap(range_low, range_high, 1'b1);
						end
						pend_valid_q <= 1'b0;
						count_q      <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/interval_union_complement_core.sv =====
// Interval union complement core.
// The input channel (in_valid / in_stall / in_data) takes one excluded interval
// per transaction; last_interval closes the set. Intervals are kept sorted by
// lower end in an internal memory by an insertion walk from the top entry;
// in_stall is high while the walk runs. An interval arriving while
// MAX_INTERVALS are stored is dropped, its last flag still counts.
// After the closing transaction the stored intervals are read back in order,
// one memory read per cycle while no stall holds the merge pass, merged, and
// the free gaps of [range_low, range_high] leave on the output channel
// (out_valid / out_stall / out_data), the final one flagged by last_gap; with
// no gap the whole range is sent. A stall holds the output transaction and
// freezes the merge pass once a further gap is ready. No new interval is taken
// until the last gap is registered. The range registers are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while idle, as
// the block itself does not enforce it. Reset empties the interval set and
// loads range 0 to 1.0; the memory itself is not cleared.
module interval_union_complement_core import icu_pkg::*; #(
	parameter int MAX_INTERVALS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  icu_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output icu_out_t    out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW = $clog2(MAX_INTERVALS + 1);

	logic signed [31:0] range_low_q;
	logic signed [31:0] range_high_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [63:0]        mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [63:0]        mem_rdata;

	// Range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_LOW:  range_low_q  <= $signed(cfg_data);
				CFG_RANGE_HIGH: range_high_q <= $signed(cfg_data);
				default:        range_low_q  <= range_low_q;
			endcase
		end
	end

	// Sorted interval store
	icu_mem #(
		.DEPTH (MAX_INTERVALS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Insertion and merge sequencer
	icu_seq #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.AW            (AW),
		.CW            (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.range_low  (range_low_q),
		.range_high (range_high_q),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

endmodule

// ===== dv/gap_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the range register port of the interval union
// complement core, keeps its own copy of the interval set and the range, and
// compares every gap transaction with the oldest predicted gap.
module gap_checker import icu_pkg::*; #(
	parameter int MAX_INTERVALS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  icu_in_t     in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  icu_out_t    out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          gaps_checked,
	output int          dropped
);

	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} span_t;

	span_t              held_spans[$];
	icu_out_t           expected_gaps[$];
	logic signed [31:0] win_low;
	logic signed [31:0] win_high;

	initial begin
		fail_count   = 0;
		pending      = 0;
		gaps_checked = 0;
		dropped      = 0;
	end

	// A gap with its length; a negative difference saturates to zero.
	function automatic icu_out_t make_gap(logic signed [31:0] lo, logic signed [31:0] hi);
		icu_out_t g;
		longint   diff;
		diff = longint'(hi) - longint'(lo);
		if (diff < 0)
			diff = 0;
		g.gap_low    = lo;
		g.gap_high   = hi;
		g.gap_length = diff[31:0];
		g.last_gap   = 1'b0;
		return g;
	endfunction

	// Insert an interval after every held one whose lower end is not above its own.
	function automatic void store_span(logic signed [31:0] lo, logic signed [31:0] hi);
		int    pos;
		span_t s;
		if (held_spans.size() >= MAX_INTERVALS) begin
			dropped++;
			return;
		end
		pos = 0;
		while (pos < held_spans.size() && held_spans[pos].lo <= lo)
			pos++;
		s.lo = lo;
		s.hi = hi;
		held_spans.insert(pos, s);
	endfunction

	// Merge the held intervals and queue the free gaps of the current range.
	function automatic void predict_gaps();
		icu_out_t           run[$];
		icu_out_t           g;
		logic signed [31:0] prev;
		logic signed [31:0] cur_lo;
		logic signed [31:0] cur_hi;
		prev = win_low;
		if (held_spans.size() > 0) begin
			cur_lo = held_spans[0].lo;
			cur_hi = held_spans[0].hi;
			for (int i = 1; i < held_spans.size(); i++) begin
				if (held_spans[i].lo <= cur_hi) begin
					if (held_spans[i].hi > cur_hi)
						cur_hi = held_spans[i].hi;
				end else begin
					if (cur_lo > prev)
						run.insert(run.size(), make_gap(prev, cur_lo));
					prev   = (cur_hi < win_high) ? cur_hi : win_high;
					cur_lo = held_spans[i].lo;
					cur_hi = held_spans[i].hi;
				end
			end
			if (cur_lo > prev)
				run.insert(run.size(), make_gap(prev, cur_lo));
			prev = (cur_hi < win_high) ? cur_hi : win_high;
		end
		if (prev < win_high)
			run.insert(run.size(), make_gap(prev, win_high));
		// With no gap at all the whole range is reported.
		if (run.size() == 0)
			run.insert(0, make_gap(win_low, win_high));
		for (int k = 0; k < run.size(); k++) begin
			g          = run[k];
			g.last_gap = (k == run.size() - 1);
			expected_gaps.insert(expected_gaps.size(), g);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endfunction

	// Register writes first, then the oldest gap is retired, then a new interval is taken.
	always @(posedge clk or negedge arst_n) begin : watch
		icu_out_t want;
		if (!arst_n) begin
			held_spans.delete();
			expected_gaps.delete();
			win_low  = RANGE_LOW_RST;
			win_high = RANGE_HIGH_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RANGE_LOW:  win_low  = cfg_data;
					CFG_RANGE_HIGH: win_high = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_gaps.size() == 0) begin
					$error("unexpected gap transaction %h..%h", out_data.gap_low,
						out_data.gap_high);
					fail_count++;
				end else begin
					want = expected_gaps.pop_front();
					check_field("gap_low", want.gap_low, out_data.gap_low);
					check_field("gap_high", want.gap_high, out_data.gap_high);
					check_field("gap_length", want.gap_length, out_data.gap_length);
					check_field("last_gap", 32'(want.last_gap), 32'(out_data.last_gap));
					gaps_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				store_span(in_data.interval_low, in_data.interval_high);
				if (in_data.last_interval) begin
					predict_gaps();
					held_spans.delete();
				end
			end
		end
		pending = expected_gaps.size();
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import icu_pkg::*;

	localparam int MAX_SPANS     = 32;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS   = 105;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	icu_in_t     in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	icu_out_t    out_data;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = CFG_RANGE_LOW;
	logic [31:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int gaps_checked;
	int dropped;

	int unsigned in_idle_pct   = 0;
	int unsigned out_stall_pct = 0;
	int          items_sent    = 0;
	int          sets_sent     = 0;
	int          settings_used = 0;

	// The range currently programmed, used only to aim the random intervals.
	logic signed [31:0] range_lo_now = RANGE_LOW_RST;
	logic signed [31:0] range_hi_now = RANGE_HIGH_RST;

	interval_union_complement_core #(.MAX_INTERVALS(MAX_SPANS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	gap_checker #(.MAX_INTERVALS(MAX_SPANS)) gap_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.gaps_checked(gaps_checked),
		.dropped     (dropped)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random with the current phase's probability.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// Hard limit on the run, far above the slowest correct run.
	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	// Offer one interval, with random idle cycles first, and wait until it is taken.
	task automatic send_interval(input logic [31:0] lo, input logic [31:0] hi,
			input logic is_last);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{interval_low: lo, interval_high: hi, last_interval: is_last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (is_last)
			sets_sent++;
	endtask

	// Wait until every predicted gap has arrived, then let the core settle.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both range registers, the low one and then the high one.
	task automatic set_range(input logic [31:0] lo, input logic [31:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_RANGE_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_RANGE_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we       <= 1'b0;
		range_lo_now = lo;
		range_hi_now = hi;
		settings_used++;
	endtask

	// Mostly a point inside the range, sometimes right at its ends, sometimes anywhere.
	function automatic logic [31:0] pick_point(input int unsigned span);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 78)
			return range_lo_now + $urandom_range(span);
		if (roll < 85)
			return range_lo_now + $urandom_range(3);
		if (roll < 92)
			return range_hi_now - $urandom_range(3);
		return $urandom();
	endfunction

	// One complete set: overlapping, touching, shared lower ends and reversed intervals.
	task automatic send_random_set(input int count);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] prev_lo;
		logic [31:0] prev_hi;
		int unsigned span;
		int unsigned roll;
		span = (range_hi_now > range_lo_now) ?
			32'(longint'(range_hi_now) - longint'(range_lo_now)) : 32'h0001_0000;
		prev_lo = pick_point(span);
		prev_hi = prev_lo;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 10)
				lo = prev_lo;
			else if (roll < 20)
				lo = prev_hi;
			else
				lo = pick_point(span);
			roll = $urandom_range(99);
			if (roll < 70)
				hi = lo + $urandom_range(span / 5);
			else if (roll < 80)
				hi = lo;
			else if (roll < 88)
				hi = lo - $urandom_range(span / 5);
			else
				hi = pick_point(span);
			send_interval(lo, hi, n == count - 1);
			prev_lo = lo;
			prev_hi = hi;
		end
	endtask

	initial begin : stimulus
		int phase_start;
		int phase_sets;
		int set_size;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets under the reset range of 0 to 1.0.
		send_interval(32'h0000_4000, 32'h0000_8000, 1'b1);
		// Overlap, touching ends, a shared lower end and a contained interval.
		send_interval(32'h0000_8000, 32'h0000_C000, 1'b0);
		send_interval(32'h0000_2000, 32'h0000_4000, 1'b0);
		send_interval(32'h0000_4000, 32'h0000_6000, 1'b0);
		send_interval(32'h0000_2000, 32'h0000_3000, 1'b0);
		send_interval(32'h0000_9000, 32'h0000_A000, 1'b1);
		// Intervals that stick out of the range at both ends.
		send_interval(32'hFFFF_8000, 32'h0000_1000, 1'b0);
		send_interval(32'h0000_F000, 32'h0001_8000, 1'b1);
		// Whole range covered, so the range itself comes back.
		send_interval(32'h0000_0000, 32'h0001_0000, 1'b1);
		// Upper end below lower end.
		send_interval(32'h0000_8000, 32'h0000_4000, 1'b1);
		// Extremes of the interval fields.
		send_interval(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		send_interval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_interval(32'h8000_0000, 32'h8000_0000, 1'b1);

		// Reversed range at the extremes: the length saturates to zero.
		drain();
		set_range(32'h7FFF_FFFF, 32'h8000_0000);
		send_interval(32'h0000_0000, 32'h0000_0000, 1'b1);

		// Widest possible range.
		drain();
		set_range(32'h8000_0000, 32'h7FFF_FFFF);
		send_interval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_interval(32'h0000_0000, 32'h0000_0010, 1'b1);

		// Random phases, each with its own range and handshake mix.
		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: begin
					in_idle_pct   = 0;
					out_stall_pct = 0;
					set_range(32'hFFF8_0000, 32'h0008_0000);
				end
				1: begin
					in_idle_pct   = 86;
					out_stall_pct = 0;
					set_range(32'h7FF0_0000, 32'h7FFF_FFFF);
				end
				2: begin
					in_idle_pct   = 0;
					out_stall_pct = 86;
					set_range(32'h8000_0000, 32'h8010_0000);
				end
				default: begin
					in_idle_pct   = 24;
					out_stall_pct = 24;
					set_range(32'h0000_0000, 32'h0001_0000);
				end
			endcase
			phase_start = items_sent;
			phase_sets  = 0;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				// One set per phase comes near or over the store's capacity, the rest stay small.
				if (phase_sets == 3)
					set_size = $urandom_range(36, 30);
				else
					set_size = $urandom_range(8, 1);
				send_random_set(set_size);
				phase_sets++;
			end
		end

		drain();
		$display("Covered %0d intervals in %0d sets over %0d range settings",
			items_sent, sets_sent, settings_used);
		$display("and four handshake mixes; checked %0d gaps, %0d intervals dropped.",
			gaps_checked, dropped);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
